[rtl/core/selcall_frame_decoder_top_macros.svh]
// Assertion macros for the selective-call frame decoder.
// Every macro samples on clk and is disabled while arst_n is low.
`ifndef SELCALL_FRAME_DECODER_TOP_MACROS_SVH
`define SELCALL_FRAME_DECODER_TOP_MACROS_SVH

// A property that must hold at every clock edge.
`define SFD_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// A condition that must imply a consequence in the same cycle.
`define SFD_ASSERT_IMPL(label, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (cons)) \
		else $error(msg);

`endif

[rtl/core/sfd_pkg.sv]
// Shared types and constants of the selective-call frame decoder.
// Used by the channel interfaces and the top level; depends on nothing.
package sfd_pkg;

	localparam int FRAME_TONES_DEF = 4;
	localparam int RESULT_TONES    = 4;

	localparam int TONE_W   = 8;
	localparam int CODE_W   = 16;
	localparam int CFG_W    = 16;
	localparam int CFG_IDX_W = 2;

	localparam logic [TONE_W-1:0] NO_TONE    = 8'hFF;
	localparam logic [TONE_W-1:0] START_TONE = 8'h0B;
	localparam logic [TONE_W-1:0] SQUELCH_TONE = 8'h00;
	localparam logic [7:0]        LED_BASE   = 8'h80;
	localparam logic [TONE_W-1:0] RING_INDEX_MIN = 8'd1;
	localparam logic [TONE_W-1:0] RING_INDEX_MAX = 8'd9;

	localparam logic [CODE_W-1:0] OWN_ADDRESS_RST  = 16'hFFFF;
	localparam logic [TONE_W-1:0] UNKNOWN_TONE_RST = 8'hFE;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_OWN_ADDRESS  = 2'd0,
		REG_UNKNOWN_TONE = 2'd1,
		REG_COMM_MODE    = 2'd2
	} reg_index_t;

endpackage

[rtl/core/sfd_stream_ifs.sv]
// Valid/ready channel interfaces of the selective-call frame decoder.
// Depends on sfd_pkg for the field widths.
interface sfd_tone_if;
	logic                        valid;
	logic                        ready;
	logic [sfd_pkg::TONE_W-1:0]  tone_code;

	modport source (output valid, output tone_code, input ready);
	modport sink (input valid, input tone_code, output ready);
endinterface

interface sfd_result_if;
	logic                        valid;
	logic                        ready;
	logic                        frame_done;
	logic [sfd_pkg::TONE_W-1:0]  access_index;
	logic [sfd_pkg::CODE_W-1:0]  caller_code;
	logic                        address_match;
	logic [7:0]                  led_pattern;
	logic                        ring_request;
	logic                        squelch_open;

	modport source (output valid, output frame_done, output access_index, output caller_code,
		output address_match, output led_pattern, output ring_request,
		output squelch_open, input ready);
	modport sink (input valid, input frame_done, input access_index, input caller_code,
		input address_match, input led_pattern, input ring_request,
		input squelch_open, output ready);
endinterface

[rtl/core/selcall_frame_decoder_top.sv]
// Selective-call frame decoder: collects tone frames and reports caller codes.
// Depends on sfd_pkg, sfd_stream_ifs.sv and selcall_frame_decoder_top_macros.svh.
//
//   channel   | direction | transfer carries
//   ----------+-----------+-------------------------------------------------
//   tone_in   | sink      | tone_code
//   res_out   | source    | frame_done, access_index, caller_code, flags, leds
//   cfg_*     | write     | own address, unknown tone code, mode
//
// One tone is taken every cycle unless the result stalls.
// The input register feeds the frame logic and the result register in one pass.
// Reset clears frame state, indicator register and squelch, and presets config.
// A stalled result holds the pass, and the input takes at most one more tone.
`include "selcall_frame_decoder_top_macros.svh"

module selcall_frame_decoder_top #(
	parameter int FRAME_TONES = sfd_pkg::FRAME_TONES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	sfd_tone_if.sink                      tone_in,
	sfd_result_if.source                  res_out,
	input  logic                          cfg_we,
	input  logic [sfd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [sfd_pkg::CFG_W-1:0]     cfg_data
);

	localparam int CNT_W = (FRAME_TONES > 1) ? $clog2(FRAME_TONES) : 1;
	localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(FRAME_TONES - 1);
	localparam int NT = sfd_pkg::RESULT_TONES;

	logic [sfd_pkg::CODE_W-1:0] own_address_q;
	logic [sfd_pkg::TONE_W-1:0] unknown_tone_q;
	logic                       comm_mode_q;

	logic                       s1_valid_q;
	logic [sfd_pkg::TONE_W-1:0] tone_s1;
	logic                       advance;

	logic                       collecting_q, collecting_n;
	logic [CNT_W-1:0]           cnt_q, cnt_n;
	logic [sfd_pkg::TONE_W-1:0] tone_buf_q [NT];
	logic [sfd_pkg::TONE_W-1:0] tone_buf_w [NT];
	logic [sfd_pkg::TONE_W-1:0] tone_buf_n [NT];
	logic [7:0]                 led_q, led_n;
	logic                       squelch_q, squelch_n;

	logic                       known;
	logic                       done;
	logic [7:0]                 low_byte;
	logic [sfd_pkg::CODE_W-1:0] code_w;
	logic                       match;
	logic                       ring;

	logic                       out_valid_q;
	logic                       done_q;
	logic [sfd_pkg::TONE_W-1:0] index_q;
	logic [sfd_pkg::CODE_W-1:0] code_q;
	logic                       match_q;
	logic                       ring_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_address_q  <= sfd_pkg::OWN_ADDRESS_RST;
			unknown_tone_q <= sfd_pkg::UNKNOWN_TONE_RST;
			comm_mode_q    <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				sfd_pkg::REG_OWN_ADDRESS:  own_address_q  <= cfg_data;
				sfd_pkg::REG_UNKNOWN_TONE: unknown_tone_q <= cfg_data[sfd_pkg::TONE_W-1:0];
				sfd_pkg::REG_COMM_MODE:    comm_mode_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign advance       = s1_valid_q && (!out_valid_q || res_out.ready);
	assign tone_in.ready = !s1_valid_q || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (tone_in.valid && tone_in.ready) begin
			s1_valid_q <= 1'b1;
		end else if (advance) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tone_in.valid && tone_in.ready) begin
			tone_s1 <= tone_in.tone_code;
		end
	end

	always_comb begin
		known        = (tone_s1 != sfd_pkg::NO_TONE) && (tone_s1 != unknown_tone_q);
		collecting_n = collecting_q;
		cnt_n        = cnt_q;
		done         = 1'b0;
		squelch_n    = squelch_q;
		for (int i = 0; i < NT; i++) begin
			tone_buf_w[i] = tone_buf_q[i];
			if (!comm_mode_q && known && collecting_q && (i < FRAME_TONES)
				&& (cnt_q == CNT_W'(i))) begin
				tone_buf_w[i] = tone_s1;
			end
		end
		for (int i = 0; i < NT; i++) begin
			tone_buf_n[i] = tone_buf_w[i];
		end
		if (!comm_mode_q) begin
			if (known) begin
				if (collecting_q) begin
					if (cnt_q == LAST_CNT) begin
						done         = 1'b1;
						cnt_n        = '0;
						collecting_n = 1'b0;
					end else begin
						cnt_n = cnt_q + 1'b1;
					end
				end
				if (tone_s1 == sfd_pkg::START_TONE) begin
					cnt_n        = '0;
					collecting_n = 1'b1;
					for (int i = 0; i < NT; i++) begin
						tone_buf_n[i] = '0;
					end
				end
			end else begin
				cnt_n        = '0;
				collecting_n = 1'b0;
			end
		end else begin
			squelch_n = (tone_s1 == sfd_pkg::SQUELCH_TONE);
		end
	end

	assign low_byte = {tone_buf_w[2][3:0], 4'b0000} + tone_buf_w[3];
	assign code_w   = {tone_buf_w[1], low_byte};
	assign match    = done && (code_w == own_address_q);
	assign ring     = match && (tone_buf_w[0] >= sfd_pkg::RING_INDEX_MIN)
		&& (tone_buf_w[0] <= sfd_pkg::RING_INDEX_MAX);

	always_comb begin
		led_n = led_q;
		if (ring) begin
			led_n = sfd_pkg::LED_BASE >> tone_buf_w[0][3:0];
		end else if (done && !match) begin
			led_n = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			collecting_q <= 1'b0;
			cnt_q        <= '0;
			led_q        <= '0;
			squelch_q    <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (advance) begin
				collecting_q <= collecting_n;
				cnt_q        <= cnt_n;
				led_q        <= led_n;
				squelch_q    <= squelch_n;
				out_valid_q  <= 1'b1;
			end else if (res_out.ready) begin
				out_valid_q  <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			tone_buf_q <= tone_buf_n;
			done_q     <= done;
			index_q    <= done ? tone_buf_w[0] : '0;
			code_q     <= done ? code_w : '0;
			match_q    <= match;
			ring_q     <= ring;
		end
	end

	assign res_out.valid         = out_valid_q;
	assign res_out.frame_done    = done_q;
	assign res_out.access_index  = index_q;
	assign res_out.caller_code   = code_q;
	assign res_out.address_match = match_q;
	assign res_out.led_pattern   = led_q;
	assign res_out.ring_request  = ring_q;
	assign res_out.squelch_open  = squelch_q;

	`SFD_ASSERT_IMPL(a_idle_fields, out_valid_q && !done_q, (code_q == '0) && (index_q == '0) && !match_q && !ring_q, "Result without a frame carries frame fields.")
	`SFD_ASSERT_IMPL(a_ring_needs_match, out_valid_q && ring_q, match_q && done_q, "Ring request without an address match.")
	`SFD_ASSERT(a_count_range, cnt_q <= LAST_CNT, "Tone count ran past the frame length.")
	`SFD_ASSERT_IMPL(a_count_idle, !collecting_q, cnt_q == '0, "Tone count is nonzero outside a frame.")
	`SFD_ASSERT_IMPL(a_stall_only, !tone_in.ready, s1_valid_q && out_valid_q && !res_out.ready, "Input stalled while the result side is free.")

endmodule
